// File: rtl/hashed_timer_wheel_defines.svh
// Assertion macros for the hashed timer wheel checker.
`ifndef HASHED_TIMER_WHEEL_DEFINES_SVH
`define HASHED_TIMER_WHEEL_DEFINES_SVH
// Implication checked on every clock outside reset.
`define HTW_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HTW_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/htw_pkg.sv
// Shared types and constants of the hashed timer wheel.
package htw_pkg;
  localparam int MaxTimersDef = 32;
  localparam int SlotsDef = 256;
  localparam int IdW = 5;
  localparam int ToW = 32;
  localparam int CntW = 16;
  localparam int SiW = 16;
  localparam int SuW = 9;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic REG_SLOT_INTERVAL = 1'b0;
  localparam logic REG_SLOTS_IN_USE = 1'b1;

  // request from control to the divider
  typedef struct packed {
    logic            go;
    logic [ToW-1:0]  dividend;
    logic [ToW-1:0]  divisor;
  } htw_div_req_t;

  typedef struct packed {
    logic            done;
    logic [ToW-1:0]  quot;
    logic [ToW-1:0]  rem;
  } htw_div_rsp_t;
endpackage

// File: rtl/hashed_timer_wheel.sv
// Hashed timer wheel: top level with control, entry memory and divider.
//
// Every division goes through one bit-serial divider. An insert keeps busy
// high after it is accepted for its steps: timeout by slot interval, then
// ticks by slot count, then one memory write. A tick keeps busy high while
// each pool entry gets a memory read state and an examine state, and one
// closing state follows. Each entry that fires and is re-armed adds the two
// divisions and the memory write of an insert. Either transaction first adds
// a division when the current slot is not below the slots in use, because the
// slot must then be reduced. A fired result is held back until the next one
// fires, so that the final one of a tick can carry last. The final result of
// a tick, either the last fired entry or the empty marker, is shown in the
// same cycle that busy falls. Each result is on the ports for one cycle with
// done; the receiver cannot stall them. There is no clearing pass, because
// the active bits reset in flops.
module hashed_timer_wheel #(
  parameter int MAX_TIMERS = htw_pkg::MaxTimersDef,
  parameter int SLOTS = htw_pkg::SlotsDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode,
  input  logic [htw_pkg::IdW-1:0]    timer_id,
  input  logic [htw_pkg::ToW-1:0]    timeout,
  input  logic [htw_pkg::CntW-1:0]   repeat_count,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [htw_pkg::SiW-1:0]    cfg_data,
  output logic                       done,
  output logic                       fired,
  output logic [htw_pkg::IdW-1:0]    expired_id,
  output logic                       last
);
  import htw_pkg::*;

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = SW + ToW + ToW + CntW;

  typedef enum logic [3:0] {
    S_IDLE, S_CMOD, S_DIV1, S_DIV2, S_WRITE, S_RD, S_EXAM, S_ARM1, S_ARM2, S_ARMW,
    S_EMIT
  } st_t;

  st_t st;
  logic [SiW-1:0] slot_interval;
  logic [SuW-1:0] slots_in_use;
  logic [SW-1:0]  cur_slot;
  logic [MAX_TIMERS-1:0] active;

  // entry memory: slot, rotation, stored timeout, remaining
  logic [EW-1:0] mem [MAX_TIMERS];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [SW-1:0]  e_slot;
  logic [ToW-1:0] e_rot, e_ivl;
  logic [CntW-1:0] e_rem;
  assign {e_slot, e_rot, e_ivl, e_rem} = rdata;

  // effective configuration
  logic [ToW-1:0] si_eff;
  logic [SuW:0]   s_eff;
  always_comb begin
    si_eff = (slot_interval == '0) ? ToW'(1) : ToW'(slot_interval);
    if (slots_in_use == '0) s_eff = (SuW+1)'(1);
    else if (32'(slots_in_use) > SLOTS) s_eff = (SuW+1)'(SLOTS);
    else s_eff = (SuW+1)'(slots_in_use);
  end

  htw_div_req_t dreq;
  htw_div_rsp_t drsp;
  htw_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [AW-1:0]   idx;
  logic            op;
  logic [ToW-1:0]  a_to;
  logic [CntW-1:0] a_rem;
  logic [ToW-1:0]  ticks;
  logic            go1, go2, go3;
  logic            pend;
  logic [IdW-1:0]  pend_id;
  logic [AW:0]     cnt;
  logic [SW-1:0]   cmod;
  logic [SuW:0]    sum;
  logic [SW-1:0]   new_slot;
  logic            last_entry;
  logic            hit;
  logic            rearm;

  always_comb begin
    // new slot from the reduced current slot and ticks modulo slot count
    sum = (SuW+1)'(cmod) + (SuW+1)'(drsp.rem);
    if (sum >= s_eff) sum = sum - s_eff;
    new_slot = SW'(sum);
    dreq.go = go1 | go2 | go3;
    dreq.dividend = go1 ? a_to : (go2 ? ticks : ToW'(cur_slot));
    dreq.divisor = go1 ? si_eff : ToW'(s_eff);
    raddr = idx;
    last_entry = (32'(cnt) == MAX_TIMERS - 1);
    hit = active[idx] && (e_slot == cur_slot);
    rearm = hit && (e_rot == '0) && (e_rem > CntW'(1));
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      active <= '0;
      cur_slot <= '0;
      slot_interval <= SiW'(1);
      slots_in_use <= SuW'(256);
      go1 <= 1'b0;
      go2 <= 1'b0;
      go3 <= 1'b0;
      we <= 1'b0;
      pend <= 1'b0;
    end else begin
      done <= 1'b0;
      go1 <= 1'b0;
      go2 <= 1'b0;
      go3 <= 1'b0;
      we <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOT_INTERVAL: slot_interval <= cfg_data;
          REG_SLOTS_IN_USE:  slots_in_use <= cfg_data[SuW-1:0];
          default: ;
        endcase
      end
      case (st)
        S_IDLE: if (start) begin
          if (opcode == OP_TICK || 32'(timer_id) < MAX_TIMERS) begin
            busy <= 1'b1;
            op <= opcode;
            idx <= (opcode == OP_INSERT) ? AW'(timer_id) : '0;
            cnt <= '0;
            pend <= 1'b0;
            a_to <= timeout;
            a_rem <= (repeat_count == '0) ? CntW'(1) : repeat_count;
            if (32'(cur_slot) >= 32'(s_eff)) begin
              // current slot lies outside the slots in use: reduce it first
              go3 <= 1'b1;
              st <= S_CMOD;
            end else begin
              cmod <= cur_slot;
              if (opcode == OP_INSERT) begin
                go1 <= 1'b1;
                st <= S_DIV1;
              end else begin
                st <= S_RD;
              end
            end
          end
        end
        S_CMOD: if (drsp.done) begin
          cmod <= SW'(drsp.rem);
          if (op == OP_INSERT) begin
            go1 <= 1'b1;
            st <= S_DIV1;
          end else begin
            st <= S_RD;
          end
        end
        S_DIV1: if (drsp.done) begin
          ticks <= (a_to < si_eff) ? ToW'(1) : drsp.quot;
          go2 <= 1'b1;
          st <= S_DIV2;
        end
        S_DIV2: if (drsp.done) begin
          we <= 1'b1;
          waddr <= idx;
          wdata <= {new_slot, drsp.quot, a_to, a_rem};
          active[idx] <= 1'b1;
          st <= S_WRITE;
        end
        S_WRITE: begin
          st <= S_IDLE;
          busy <= 1'b0;
        end
        S_RD: st <= S_EXAM;
        S_EXAM: begin
          if (hit && e_rot != '0) begin
            we <= 1'b1;
            waddr <= idx;
            wdata <= {e_slot, e_rot - ToW'(1), e_ivl, e_rem};
          end else if (hit) begin
            // send the held result; hold this one back
            if (pend) begin
              done <= 1'b1;
              fired <= 1'b1;
              expired_id <= pend_id;
              last <= 1'b0;
            end
            pend <= 1'b1;
            pend_id <= IdW'(idx);
            if (rearm) begin
              a_to <= e_ivl;
              a_rem <= e_rem - CntW'(1);
              go1 <= 1'b1;
            end else begin
              active[idx] <= 1'b0;
            end
          end
          if (rearm) st <= S_ARM1;
          else if (last_entry) st <= S_EMIT;
          else begin
            st <= S_RD;
            idx <= idx + AW'(1);
            cnt <= cnt + (AW+1)'(1);
          end
        end
        S_ARM1: if (drsp.done) begin
          ticks <= (a_to < si_eff) ? ToW'(1) : drsp.quot;
          go2 <= 1'b1;
          st <= S_ARM2;
        end
        S_ARM2: if (drsp.done) begin
          we <= 1'b1;
          waddr <= idx;
          wdata <= {new_slot, drsp.quot, a_to, a_rem};
          st <= S_ARMW;
        end
        S_ARMW: begin
          if (last_entry) st <= S_EMIT;
          else begin
            idx <= idx + AW'(1);
            cnt <= cnt + (AW+1)'(1);
            st <= S_RD;
          end
        end
        S_EMIT: begin
          // final result of the tick: held fired entry or empty marker
          done <= 1'b1;
          fired <= pend;
          expired_id <= pend ? pend_id : '0;
          last <= 1'b1;
          if (32'(cmod) + 32'd1 >= 32'(s_eff)) cur_slot <= '0;
          else cur_slot <= cmod + SW'(1);
          busy <= 1'b0;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/htw_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module htw_div (
  input  logic                  clk,
  input  logic                  rst,
  input  htw_pkg::htw_div_req_t req,
  output htw_pkg::htw_div_rsp_t rsp
);
  import htw_pkg::*;

  logic [ToW-1:0] q;
  logic [ToW:0]   r;
  logic [ToW-1:0] d;
  logic [5:0]     cnt;
  logic           run;
  logic           done;
  logic [ToW:0]   shifted;
  logic [ToW:0]   diff;

  always_comb begin
    shifted = {r[ToW-1:0], q[ToW-1]};
    diff = shifted - {1'b0, d};
  end

  // shift/subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
        q <= req.dividend;
        d <= req.divisor;
        r <= '0;
        cnt <= 6'(ToW);
      end else if (run) begin
        if (diff[ToW]) begin
          r <= shifted;
          q <= {q[ToW-2:0], 1'b0};
        end else begin
          r <= diff;
          q <= {q[ToW-2:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = r[ToW-1:0];
endmodule

// File: rtl/htw_checker.sv
// Port-level checker for the hashed timer wheel, bound to the top level.
`include "hashed_timer_wheel_defines.svh"
module htw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic fired,
  input logic last
);
  `HTW_ASSERT_IMP(a_marker_last, done && !fired, last)
  `HTW_ASSERT_NEXT(a_busy_after_last, done && last, !done)
  `HTW_ASSERT_IMP(a_done_busy, done && !last, busy)
endmodule

bind hashed_timer_wheel htw_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .fired(fired), .last(last)
);

// File: tb/tb_hashed_timer_wheel.sv
// Self-checking testbench for the hashed timer wheel: random and directed timer traffic.
module tb_hashed_timer_wheel;
  import htw_pkg::*;

  localparam int NumTimers = 32;
  localparam int NumSlots = 256;
  localparam int DrainCycles = 200;
  localparam int CycleLimit = 5000000;

  typedef struct {
    logic            op;
    logic [IdW-1:0]  id;
    logic [ToW-1:0]  tmo;
    logic [CntW-1:0] cnt;
  } wheel_cmd_t;

  typedef struct {
    logic           fired;
    logic [IdW-1:0] id;
    logic           last;
  } expiry_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic opcode;
  logic [IdW-1:0] timer_id;
  logic [ToW-1:0] timeout;
  logic [CntW-1:0] repeat_count;
  logic cfg_we;
  logic cfg_index;
  logic [SiW-1:0] cfg_data;
  logic done;
  logic fired;
  logic [IdW-1:0] expired_id;
  logic last;

  hashed_timer_wheel dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .timer_id(timer_id), .timeout(timeout),
    .repeat_count(repeat_count), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .fired(fired),
    .expired_id(expired_id), .last(last)
  );

  // Wheel state mirrored by the predictor
  logic [SiW-1:0]  interval_reg;
  logic [SuW-1:0]  slot_count_reg;
  logic            tmr_active [NumTimers];
  int unsigned     tmr_slot [NumTimers];
  logic [31:0]     tmr_rot [NumTimers];
  logic [31:0]     tmr_period [NumTimers];
  logic [15:0]     tmr_left [NumTimers];
  int unsigned     wheel_pos;

  wheel_cmd_t cmd_q[$];
  expiry_t    expiry_q[$];
  int         errors;
  int         cycles;
  bit         no_gaps;
  bit         in_flight;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int unsigned live_slots();
    int unsigned s;
    s = slot_count_reg;
    if (s == 0) s = 1;
    if (s > NumSlots) s = NumSlots;
    return s;
  endfunction

  // Place a timer on the wheel from the current position
  function automatic void wheel_arm(int id, logic [31:0] tmo);
    logic [31:0] si;
    logic [31:0] ticks;
    int unsigned s;
    si = (interval_reg == 0) ? 32'd1 : 32'(interval_reg);
    s = live_slots();
    ticks = (tmo < si) ? 32'd1 : tmo / si;
    tmr_rot[id] = ticks / s;
    tmr_slot[id] = ((wheel_pos % s) + ticks % s) % s;
    tmr_period[id] = tmo;
    tmr_active[id] = 1'b1;
  endfunction

  // Apply one command and queue the expirations it produces
  function automatic void wheel_step(wheel_cmd_t c);
    logic here [NumTimers];
    int unsigned s;
    int n;
    expiry_t e;
    if (c.op == OP_INSERT) begin
      tmr_left[c.id] = (c.cnt == 0) ? 16'd1 : c.cnt;
      wheel_arm(int'(c.id), c.tmo);
      return;
    end
    s = live_slots();
    n = 0;
    for (int i = 0; i < NumTimers; i++)
      here[i] = tmr_active[i] && tmr_slot[i] == wheel_pos;
    for (int i = 0; i < NumTimers; i++) begin
      if (!here[i]) continue;
      if (tmr_rot[i] > 0) begin
        tmr_rot[i]--;
        continue;
      end
      e.fired = 1'b1;
      e.id = IdW'(i);
      e.last = 1'b0;
      expiry_q.push_back(e);
      n++;
      if (tmr_left[i] > 0) tmr_left[i]--;
      if (tmr_left[i] > 0) wheel_arm(i, tmr_period[i]);
      else tmr_active[i] = 1'b0;
    end
    if (n == 0) begin
      e.fired = 1'b0;
      e.id = '0;
      e.last = 1'b1;
      expiry_q.push_back(e);
    end else begin
      expiry_q[$].last = 1'b1;
    end
    wheel_pos = ((wheel_pos % s) + 1) % s;
  endfunction

  // Driver: present the head command, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !in_flight) begin
      start <= 1'b1;
    end else if (cmd_q.size() > 0 && (no_gaps || $urandom_range(99) >= 21)) begin
      start <= 1'b1;
      opcode <= cmd_q[0].op;
      timer_id <= cmd_q[0].id;
      timeout <= cmd_q[0].tmo;
      repeat_count <= cmd_q[0].cnt;
    end else begin
      start <= 1'b0;
      opcode <= $urandom_range(1);
      timer_id <= $urandom;
      timeout <= $urandom;
      repeat_count <= $urandom;
    end
  end

  // Acceptance: predict on each taken transaction
  always @(posedge clk) begin
    in_flight = 1'b0;
    if (!rst && start && !busy) begin
      wheel_step(cmd_q.pop_front());
      in_flight = 1'b1;
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    expiry_t e;
    if (!rst && done) begin
      if (expiry_q.size() == 0) begin
        $display("%0t: unexpected result fired=%0d id=%0d last=%0d",
                 $time, fired, expired_id, last);
        errors++;
      end else begin
        e = expiry_q.pop_front();
        if (fired !== e.fired) begin
          $display("%0t: fired exp %0d got %0d", $time, e.fired, fired);
          errors++;
        end
        if (expired_id !== e.id) begin
          $display("%0t: expired_id exp %0d got %0d", $time, e.id, expired_id);
          errors++;
        end
        if (last !== e.last) begin
          $display("%0t: last exp %0d got %0d", $time, e.last, last);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void add_cmd(logic op, int id, logic [31:0] tmo, int cnt);
    wheel_cmd_t c;
    c.op = op;
    c.id = IdW'(id);
    c.tmo = tmo;
    c.cnt = CntW'(cnt);
    cmd_q.push_back(c);
  endfunction

  task automatic wait_idle();
    while (cmd_q.size() > 0 || expiry_q.size() > 0 || start || busy) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SiW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SLOT_INTERVAL) interval_reg = val;
    else slot_count_reg = SuW'(val);
  endtask

  // Random traffic, mostly short timers so that they fire often
  task automatic random_phase(int count);
    int unsigned span;
    logic [31:0] tmo;
    int cnt;
    span = ((interval_reg == 0) ? 1 : interval_reg) * live_slots();
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 55) begin
        add_cmd(OP_TICK, $urandom, $urandom, $urandom);
      end else begin
        tmo = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 3 * span);
        cnt = ($urandom_range(19) == 0) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 4);
        add_cmd(OP_INSERT, $urandom_range(31), tmo, cnt);
      end
    end
  endtask

  initial begin
    int si_set [7];
    int su_set [7];
    si_set = '{3, 0, 65535, 7, 2, 5, 1};
    su_set = '{8, 5, 2, 0, 300, 256, 1};
    errors = 0;
    cycles = 0;
    no_gaps = 1'b0;
    in_flight = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_INSERT;
    timer_id = '0;
    timeout = '0;
    repeat_count = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SLOT_INTERVAL;
    cfg_data = '0;
    interval_reg = 1;
    slot_count_reg = 256;
    wheel_pos = 0;
    for (int i = 0; i < NumTimers; i++) begin
      tmr_active[i] = 1'b0;
      tmr_slot[i] = 0;
      tmr_rot[i] = 0;
      tmr_period[i] = 0;
      tmr_left[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: same slot ordering, zero timeout, zero count, restart, extremes
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_INSERT, 2, 1, 1);
    add_cmd(OP_INSERT, 1, 1, 2);
    add_cmd(OP_INSERT, 3, 0, 0);
    add_cmd(OP_INSERT, 31, 32'hFFFF_FFFF, 16'hFFFF);
    add_cmd(OP_INSERT, 0, 2, 3);
    add_cmd(OP_INSERT, 5, 4, 1);
    add_cmd(OP_INSERT, 5, 256, 1);
    add_cmd(OP_INSERT, 6, 257, 2);
    for (int k = 0; k < 6; k++) add_cmd(OP_TICK, 31, 32'hFFFF_FFFF, 16'hFFFF);
    wait_idle();

    // Configuration sweep with random traffic per setting
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_SLOT_INTERVAL, SiW'(si_set[p]));
      write_reg(REG_SLOTS_IN_USE, SiW'(su_set[p]));
      no_gaps = (p == 2);
      random_phase(60);
      wait_idle();
    end

    if (expiry_q.size() > 0) errors++;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
